// File: hw/rtl/qte_pkg.sv
package qte_pkg;

   localparam int CORDIC_STEPS = 14;
   localparam int TAB_LEN      = 24;
   localparam int CS_RUN       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

   localparam int QW      = 16;
   localparam int PW      = 2 * QW;
   localparam int TW      = 36;
   localparam int CW      = 30;
   localparam int XW      = 40;
   localparam int AW      = 28;
   localparam int SQW     = 57;
   localparam int SQ_STEPS = 29;
   localparam int STEP_W  = 5;
   localparam int FRAC_SH = 11;

   localparam logic signed [TW-1:0] ONE_Q28     = TW'(64'sd268435456);
   localparam logic signed [AW-1:0] HALF_PI_Q24 = AW'(64'sd26353589);
   localparam logic signed [AW:0]   ROUND_Q24   = (AW+1)'(64'sd1024);
   localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
   localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] ang;
      logic                 zero;
   } cor_lane_type;

   typedef struct packed {
      cor_lane_type         yaw;
      cor_lane_type         roll;
      logic signed [CW-1:0] t2;
   } pass_type;

   function automatic logic signed [AW-1:0] atan_entry(input logic [STEP_W-1:0] step);
      logic signed [AW-1:0] r;
      case (step)
         5'd0:  r = AW'(64'sd13176795);
         5'd1:  r = AW'(64'sd7778716);
         5'd2:  r = AW'(64'sd4110060);
         5'd3:  r = AW'(64'sd2086331);
         5'd4:  r = AW'(64'sd1047214);
         5'd5:  r = AW'(64'sd524117);
         5'd6:  r = AW'(64'sd262123);
         5'd7:  r = AW'(64'sd131069);
         5'd8:  r = AW'(64'sd65536);
         5'd9:  r = AW'(64'sd32768);
         5'd10: r = AW'(64'sd16384);
         5'd11: r = AW'(64'sd8192);
         5'd12: r = AW'(64'sd4096);
         5'd13: r = AW'(64'sd2048);
         5'd14: r = AW'(64'sd1024);
         5'd15: r = AW'(64'sd512);
         5'd16: r = AW'(64'sd256);
         5'd17: r = AW'(64'sd128);
         5'd18: r = AW'(64'sd64);
         5'd19: r = AW'(64'sd32);
         5'd20: r = AW'(64'sd16);
         5'd21: r = AW'(64'sd8);
         5'd22: r = AW'(64'sd4);
         5'd23: r = AW'(64'sd2);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_angles.sv
// Converts one Q1.14 quaternion per clock, unless rsp_stall holds the pipeline, into
// yaw and roll (Q2.13 radians) and pitch (Q1.13 radians). Fully pipelined, through
// the multiply/sum/square front end, the 29-cell bit-serial square root for the pitch
// cosine, the chain of CORDIC cells and an output register. Each stage holds its
// transaction while the next one cannot advance, so rsp_stall backs up stage by stage.
module quaternion_to_euler_angles (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [15:0]      req_quat_w,
   input  logic signed [15:0]      req_quat_x,
   input  logic signed [15:0]      req_quat_y,
   input  logic signed [15:0]      req_quat_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [15:0]      rsp_yaw_angle,
   output logic signed [14:0]      rsp_pitch_angle,
   output logic signed [15:0]      rsp_roll_angle
);
   import qte_pkg::*;

   localparam int ST_SUM   = 1;
   localparam int ST_SQ    = 2;
   localparam int ST_SQRT0 = 3;
   localparam int ST_COR0  = ST_SQRT0 + SQ_STEPS;
   localparam int ST_OUT   = ST_COR0 + CS_RUN;
   localparam int NST      = ST_OUT + 1;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] adv;

   logic signed [PW-1:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff, p_wx_ff;
   logic signed [PW-1:0] p_yz_ff, p_wy_ff, p_zx_ff, p_xx_ff;
   logic signed [TW-1:0] t0_ff, t1_ff, t3_ff, t4_ff;
   logic signed [CW-1:0] t2_ff;
   logic signed [TW-1:0] t2_raw;
   logic signed [CW-1:0] t2_clip;
   logic signed [2*CW-1:0] t2_sq;
   logic [SQW-1:0]       n_ff;
   pass_type             pass_ff [SQ_STEPS+1];

   logic [SQW-1:0] rem_w [SQ_STEPS+1];
   logic [SQW-1:0] res_w [SQ_STEPS+1];

   cor_lane_type yaw_w   [CS_RUN+1];
   cor_lane_type pitch_w [CS_RUN+1];
   cor_lane_type roll_w  [CS_RUN+1];

   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;

   function automatic cor_lane_type prerot(input logic signed [TW-1:0] y,
                                           input logic signed [TW-1:0] x);
      cor_lane_type r;
      r.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         if (y >= 0) begin
            r.x   = XW'(y);
            r.y   = -XW'(x);
            r.ang = HALF_PI_Q24;
         end else begin
            r.x   = -XW'(y);
            r.y   = XW'(x);
            r.ang = -HALF_PI_Q24;
         end
      end else begin
         r.x   = XW'(x);
         r.y   = XW'(y);
         r.ang = '0;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_q13(input cor_lane_type l,
                                                 input logic signed [15:0] lim);
      logic signed [AW:0]         s;
      logic signed [AW-FRAC_SH:0] r;
      logic signed [AW-FRAC_SH:0] lim_w;
      s     = (AW+1)'(l.ang) + ROUND_Q24;
      r     = (AW-FRAC_SH+1)'(s >>> FRAC_SH);
      lim_w = (AW-FRAC_SH+1)'(lim);
      if (l.zero) begin
         r = '0;
      end else if (r > lim_w) begin
         r = lim_w;
      end else if (r < -lim_w) begin
         r = -lim_w;
      end
      return 16'(r);
   endfunction

   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int i = NST - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      for (int i = 0; i < NST; i++) begin
         if (adv[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p_wz_ff <= PW'(req_quat_w * req_quat_z);
         p_xy_ff <= PW'(req_quat_x * req_quat_y);
         p_yy_ff <= PW'(req_quat_y * req_quat_y);
         p_zz_ff <= PW'(req_quat_z * req_quat_z);
         p_wx_ff <= PW'(req_quat_w * req_quat_x);
         p_yz_ff <= PW'(req_quat_y * req_quat_z);
         p_wy_ff <= PW'(req_quat_w * req_quat_y);
         p_zx_ff <= PW'(req_quat_z * req_quat_x);
         p_xx_ff <= PW'(req_quat_x * req_quat_x);
      end
   end

   always_comb begin
      t2_raw = (TW'(p_wx_ff) - TW'(p_yz_ff)) <<< 1;
      if (t2_raw > ONE_Q28) begin
         t2_clip = CW'(ONE_Q28);
      end else if (t2_raw < -ONE_Q28) begin
         t2_clip = -CW'(ONE_Q28);
      end else begin
         t2_clip = CW'(t2_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SUM]) begin
         t3_ff <= (TW'(p_wz_ff) + TW'(p_xy_ff)) <<< 1;
         t4_ff <= ONE_Q28 - ((TW'(p_yy_ff) + TW'(p_zz_ff)) <<< 1);
         t0_ff <= (TW'(p_wy_ff) + TW'(p_zx_ff)) <<< 1;
         t1_ff <= ONE_Q28 - ((TW'(p_xx_ff) + TW'(p_yy_ff)) <<< 1);
         t2_ff <= t2_clip;
      end
   end

   assign t2_sq = t2_ff * t2_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_SQ]) begin
         n_ff            <= (SQW'(1) << (SQW - 1)) - SQW'(t2_sq);
         pass_ff[0].yaw  <= prerot(t3_ff, t4_ff);
         pass_ff[0].roll <= prerot(t0_ff, t1_ff);
         pass_ff[0].t2   <= t2_ff;
      end
   end

   assign rem_w[0] = n_ff;
   assign res_w[0] = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock   (clock),
         .advance (adv[ST_SQRT0+k]),
         .step    (STEP_W'(k)),
         .rem_i   (rem_w[k]),
         .res_i   (res_w[k]),
         .rem_ff  (rem_w[k+1]),
         .res_ff  (res_w[k+1])
      );

      always_ff @(posedge clock) begin
         if (adv[ST_SQRT0+k]) begin
            pass_ff[k+1] <= pass_ff[k];
         end
      end
   end

   always_comb begin
      yaw_w[0]        = pass_ff[SQ_STEPS].yaw;
      roll_w[0]       = pass_ff[SQ_STEPS].roll;
      pitch_w[0].x    = XW'({1'b0, res_w[SQ_STEPS][CW-1:0]});
      pitch_w[0].y    = XW'(pass_ff[SQ_STEPS].t2);
      pitch_w[0].ang  = '0;
      pitch_w[0].zero = 1'b0;
   end

   for (genvar j = 0; j < CS_RUN; j++) begin : g_cordic
      qte_cordic_cell u_yaw (
         .clock   (clock),
         .advance (adv[ST_COR0+j]),
         .step    (STEP_W'(j)),
         .lane_i  (yaw_w[j]),
         .lane_ff (yaw_w[j+1])
      );
      qte_cordic_cell u_pitch (
         .clock   (clock),
         .advance (adv[ST_COR0+j]),
         .step    (STEP_W'(j)),
         .lane_i  (pitch_w[j]),
         .lane_ff (pitch_w[j+1])
      );
      qte_cordic_cell u_roll (
         .clock   (clock),
         .advance (adv[ST_COR0+j]),
         .step    (STEP_W'(j)),
         .lane_i  (roll_w[j]),
         .lane_ff (roll_w[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         yaw_ff   <= to_q13(yaw_w[CS_RUN], PI_Q13);
         pitch_ff <= 15'(to_q13(pitch_w[CS_RUN], HALF_PI_Q13));
         roll_ff  <= to_q13(roll_w[CS_RUN], PI_Q13);
      end
   end

   assign req_stall       = !adv[0];
   assign rsp_valid       = vld_ff[ST_OUT];
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

endmodule

// File: hw/rtl/qte_sqrt_cell.sv
module qte_sqrt_cell (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [qte_pkg::STEP_W-1:0]      step,
   input  logic [qte_pkg::SQW-1:0]         rem_i,
   input  logic [qte_pkg::SQW-1:0]         res_i,
   output logic [qte_pkg::SQW-1:0]         rem_ff,
   output logic [qte_pkg::SQW-1:0]         res_ff
);
   import qte_pkg::*;

   logic [5:0]     sh;
   logic [SQW-1:0] one_w;
   logic [SQW-1:0] sum_w;
   logic [SQW-1:0] rem_in;
   logic [SQW-1:0] res_in;

   always_comb begin
      sh     = 6'(SQW - 1) - {step, 1'b0};
      one_w  = SQW'(1) << sh;
      sum_w  = res_i + one_w;
      if (rem_i >= sum_w) begin
         rem_in = rem_i - sum_w;
         res_in = (res_i >> 1) + one_w;
      end else begin
         rem_in = rem_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

endmodule

// File: hw/rtl/qte_cordic_cell.sv
module qte_cordic_cell (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [qte_pkg::STEP_W-1:0]      step,
   input  qte_pkg::cor_lane_type           lane_i,
   output qte_pkg::cor_lane_type           lane_ff
);
   import qte_pkg::*;

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [AW-1:0] da;
   cor_lane_type         lane_in;

   always_comb begin
      xs      = lane_i.x >>> step;
      ys      = lane_i.y >>> step;
      da      = atan_entry(step);
      lane_in = lane_i;
      if (lane_i.y >= 0) begin
         lane_in.x   = lane_i.x + ys;
         lane_in.y   = lane_i.y - xs;
         lane_in.ang = lane_i.ang + da;
      end else begin
         lane_in.x   = lane_i.x - ys;
         lane_in.y   = lane_i.y + xs;
         lane_in.ang = lane_i.ang - da;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// File: hw/rtl/qte_checker.sv
module qte_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_yaw_angle,
   input logic signed [14:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_roll_angle
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output drains");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_yaw_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_roll_angle)))
      else $error("stalled transaction changed");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868))
      else $error("pitch out of range");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736
         && rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736))
      else $error("yaw or roll out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_yaw_angle   (rsp_yaw_angle),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_roll_angle  (rsp_roll_angle)
);
